>>> rtl/core/fpmm_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package fpmm_pkg;

	localparam int unsigned DataWidth  = 16;
	localparam int unsigned IndexWidth = 4;
	localparam int unsigned DimWidth   = 2;
	localparam int unsigned ProdWidth  = 2 * DataWidth;

	// Step counter: element index in the upper bits, term of the dot product below.
	localparam int unsigned StepWidth = IndexWidth + DimWidth;
	localparam logic [StepWidth-1:0] LastStep = '1;
	localparam logic [DimWidth-1:0] LastTerm = '1;
	localparam logic [IndexWidth-1:0] LastIndex = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                  load;
		logic                  issue;
		logic [IndexWidth-1:0] elem;
		logic [DimWidth-1:0]   term;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic advance;
	} status_t;

endpackage

>>> rtl/core/fpmm_datapath.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply datapath
// Holds both element stores, one 16x16 multiplier, the accumulator and the
// output register.
// ----------------------------------------------------------------------------
module fpmm_datapath #(
	parameter int unsigned FRAC_BITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fpmm_pkg::cmd_t                      cmd,
	output fpmm_pkg::status_t                   status,
	input  logic [fpmm_pkg::IndexWidth-1:0]     element_index,
	input  logic signed [fpmm_pkg::DataWidth-1:0] left_value,
	input  logic signed [fpmm_pkg::DataWidth-1:0] right_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fpmm_pkg::DataWidth-1:0] product_value,
	output logic [fpmm_pkg::DimWidth-1:0]       product_row,
	output logic [fpmm_pkg::DimWidth-1:0]       product_col,
	output logic                                final_result
);

	localparam int unsigned Shift = 2 * FRAC_BITS;

	logic signed [fpmm_pkg::DataWidth-1:0] left_q  [16];
	logic signed [fpmm_pkg::DataWidth-1:0] right_q [16];

	logic                                  advance;
	logic [fpmm_pkg::IndexWidth-1:0]       left_addr;
	logic [fpmm_pkg::IndexWidth-1:0]       right_addr;
	logic signed [fpmm_pkg::ProdWidth-1:0] product_s1;
	logic                                  valid_s1;
	logic                                  first_s1;
	logic                                  last_s1;
	logic [fpmm_pkg::IndexWidth-1:0]       elem_s1;
	logic signed [fpmm_pkg::ProdWidth-1:0] shifted;
	logic [fpmm_pkg::DataWidth-1:0]        acc_q;
	logic [fpmm_pkg::DataWidth-1:0]        acc_next;

	// The pipeline moves unless a result waits in the output register and is stalled.
	assign advance = !(out_valid && out_stall);
	assign status.advance = advance;

	// Row of the left matrix and column of the right matrix for this term.
	assign left_addr  = {cmd.elem[3:2], cmd.term};
	assign right_addr = {cmd.term, cmd.elem[1:0]};

	// Element stores, cleared at reset and written on each load transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				left_q[i]  <= '0;
				right_q[i] <= '0;
			end
		end else if (cmd.load) begin
			left_q[element_index]  <= left_value;
			right_q[element_index] <= right_value;
		end
	end

	// Multiply stage: one term of one dot product per cycle while the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd.issue) begin
			product_s1 <= left_q[left_addr] * right_q[right_addr];
			first_s1   <= (cmd.term == '0);
			last_s1    <= (cmd.term == fpmm_pkg::LastTerm);
			elem_s1    <= cmd.elem;
		end
	end

	// Shift each product, then accumulate modulo 2^16.
	assign shifted  = product_s1 >>> Shift;
	assign acc_next = (first_s1 ? '0 : acc_q) + shifted[fpmm_pkg::DataWidth-1:0];

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			acc_q <= acc_next;
		end
	end

	// Output register, loaded on the last term of each element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			product_value <= acc_next;
			product_row   <= elem_s1[3:2];
			product_col   <= elem_s1[1:0];
			final_result  <= (elem_s1 == fpmm_pkg::LastIndex);
		end
	end

	// A result appears only after the last term of its dot product.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !(valid_s1 && last_s1)) |=> !out_valid)
		else $error("result produced without a completed dot product");

	// The final result always belongs to the bottom-right element.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && final_result) |-> (product_row == 2'd3 && product_col == 2'd3))
		else $error("final flag on an element other than the last");

endmodule

>>> rtl/core/fpmm_ctrl.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply controller
// Accepts loads while idle and sequences the 64 multiply-accumulate steps of a
// product.
// ----------------------------------------------------------------------------
module fpmm_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_product,
	output fpmm_pkg::cmd_t                  cmd,
	input  fpmm_pkg::status_t               status
);

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t                           state_q;
	logic [fpmm_pkg::StepWidth-1:0]   step_q;
	logic                             accept;

	assign in_stall = (state_q != IDLE);
	assign accept   = in_valid && !in_stall;

	// Commands to the datapath.
	assign cmd.load  = accept;
	assign cmd.issue = (state_q == RUN);
	assign cmd.elem  = step_q[fpmm_pkg::StepWidth-1:fpmm_pkg::DimWidth];
	assign cmd.term  = step_q[fpmm_pkg::DimWidth-1:0];

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept && start_product) begin
						state_q <= RUN;
						step_q  <= '0;
					end
				end
				RUN: begin
					if (status.advance) begin
						step_q <= step_q + 1'b1;
						if (step_q == fpmm_pkg::LastStep) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// A start transfer always begins the sequence at the first step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_product) |=> (state_q == RUN && step_q == '0))
		else $error("start transfer did not begin a product");

	// The sequence ends right after its last step is issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN && status.advance && step_q == fpmm_pkg::LastStep)
		|=> (state_q == IDLE))
		else $error("sequence did not end after the last step");

endmodule

>>> rtl/core/fixed_point_matrix4_multiply.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply, top level
// Loads two 4x4 matrices element by element and streams out their product.
// ----------------------------------------------------------------------------
// A load transfer writes one left and one right element together.
// A transfer with start_product set also starts the product: a single 16x16
// multiplier works through the 64 multiply-accumulate steps at one per cycle
// while the result side does not stall; the sixteen elements follow in
// row-major order, each passing the multiply stage and the output register.
// Input is stalled while that sequence runs; results still waiting
// in the output register drain afterward while new loads are taken. A stall
// on the result side holds the whole sequence.
module fixed_point_matrix4_multiply #(
	parameter int unsigned FRAC_BITS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [fpmm_pkg::IndexWidth-1:0]       element_index,
	input  logic signed [fpmm_pkg::DataWidth-1:0] left_value,
	input  logic signed [fpmm_pkg::DataWidth-1:0] right_value,
	input  logic                                  start_product,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fpmm_pkg::DataWidth-1:0] product_value,
	output logic [fpmm_pkg::DimWidth-1:0]         product_row,
	output logic [fpmm_pkg::DimWidth-1:0]         product_col,
	output logic                                  final_result
);

	fpmm_pkg::cmd_t    cmd;
	fpmm_pkg::status_t status;

	// Sequencer.
	fpmm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_product (start_product),
		.cmd           (cmd),
		.status        (status)
	);

	// Stores, multiplier and accumulator.
	fpmm_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.element_index (element_index),
		.left_value    (left_value),
		.right_value   (right_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.product_row   (product_row),
		.product_col   (product_col),
		.final_result  (final_result)
	);

endmodule

>>> test/fixed_point_matrix4_multiply_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply checker
// Watches the load and result channels, keeps its own copy of both matrix
// stores, predicts the sixteen product elements of every start transfer and
// compares each result transfer with the oldest element still awaited.
// ----------------------------------------------------------------------------
module fixed_point_matrix4_multiply_checker #(
	parameter int unsigned FRAC_BITS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [fpmm_pkg::IndexWidth-1:0]       element_index,
	input  logic signed [fpmm_pkg::DataWidth-1:0] left_value,
	input  logic signed [fpmm_pkg::DataWidth-1:0] right_value,
	input  logic                                  start_product,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [fpmm_pkg::DataWidth-1:0] product_value,
	input  logic [fpmm_pkg::DimWidth-1:0]         product_row,
	input  logic [fpmm_pkg::DimWidth-1:0]         product_col,
	input  logic                                  final_result,
	output int unsigned                           error_count,
	output int unsigned                           elements_awaited,
	output int unsigned                           loads_seen,
	output int unsigned                           products_started,
	output int unsigned                           elements_checked
);

	localparam int unsigned Elements = 1 << fpmm_pkg::IndexWidth;
	localparam int unsigned Dim      = 1 << fpmm_pkg::DimWidth;

	// One element of the product matrix as it appears on the result channel.
	typedef struct packed {
		logic signed [fpmm_pkg::DataWidth-1:0] value;
		logic [fpmm_pkg::DimWidth-1:0]         row;
		logic [fpmm_pkg::DimWidth-1:0]         col;
		logic                                  last;
	} product_elem_t;

	logic signed [fpmm_pkg::DataWidth-1:0] left_matrix  [Elements];
	logic signed [fpmm_pkg::DataWidth-1:0] right_matrix [Elements];
	product_elem_t                         awaited_elems[$];

	// Dot product of one left row and one right column. Each full-width product
	// is shifted arithmetically before the sum, and the sum wraps to 16 bits.
	function automatic logic [fpmm_pkg::DataWidth-1:0] dot_row_col(int unsigned row,
			int unsigned col);
		logic signed [fpmm_pkg::ProdWidth-1:0] term;
		logic [fpmm_pkg::DataWidth-1:0]        acc;
		int unsigned                           k;
		acc = '0;
		for (k = 0; k < Dim; k++) begin
			term = left_matrix[row * Dim + k] * right_matrix[k * Dim + col];
			term = term >>> (2 * FRAC_BITS);
			acc  = acc + term[fpmm_pkg::DataWidth-1:0];
		end
		return acc;
	endfunction

	// Result transfers are checked before load transfers of the same edge, so a
	// start taken in that cycle never supplies the element being compared.
	always @(posedge clk or negedge arst_n) begin
		product_elem_t got;
		product_elem_t want;
		int unsigned   r;
		int unsigned   c;
		if (!arst_n) begin
			for (r = 0; r < Elements; r++) begin
				left_matrix[r]  = '0;
				right_matrix[r] = '0;
			end
			awaited_elems.delete();
			error_count      = 0;
			loads_seen       = 0;
			products_started = 0;
			elements_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{product_value, product_row, product_col, final_result};
				elements_checked++;
				if (awaited_elems.size() == 0) begin
					error_count++;
					$display("%0t: result transfer with nothing awaited: row %0d col %0d value %0d",
						$time, got.row, got.col, got.value);
				end else begin
					want = awaited_elems.pop_front();
					if (got.value !== want.value) begin
						error_count++;
						$display("%0t: product_value at row %0d col %0d: expected %0d, got %0d",
							$time, want.row, want.col, want.value, got.value);
					end
					if (got.row !== want.row) begin
						error_count++;
						$display("%0t: product_row: expected %0d, got %0d",
							$time, want.row, got.row);
					end
					if (got.col !== want.col) begin
						error_count++;
						$display("%0t: product_col: expected %0d, got %0d",
							$time, want.col, got.col);
					end
					if (got.last !== want.last) begin
						error_count++;
						$display("%0t: final_result at row %0d col %0d: expected %0b, got %0b",
							$time, want.row, want.col, want.last, got.last);
					end
				end
			end

			// A load transfer stores first; a start then predicts the whole product.
			if (in_valid && !in_stall) begin
				loads_seen++;
				left_matrix[element_index]  = left_value;
				right_matrix[element_index] = right_value;
				if (start_product) begin
					products_started++;
					for (r = 0; r < Dim; r++) begin
						for (c = 0; c < Dim; c++) begin
							want.value = dot_row_col(r, c);
							want.row   = r[fpmm_pkg::DimWidth-1:0];
							want.col   = c[fpmm_pkg::DimWidth-1:0];
							want.last  = (r == Dim - 1) && (c == Dim - 1);
							awaited_elems.push_back(want);
						end
					end
				end
			end
		end
		elements_awaited = awaited_elems.size();
	end

endmodule

>>> test/fixed_point_matrix4_multiply_test.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix multiply testbench
// Drives directed corner loads, then mostly complete random matrix loads mixed
// with partial loads and loose element writes, with random idling on both
// channels. A separate checker predicts and compares every product element.
// ----------------------------------------------------------------------------
module fixed_point_matrix4_multiply_test;

	localparam int unsigned FRAC_BITS    = 4;
	localparam int unsigned ItemTarget   = 450;
	localparam int unsigned MaxIdle      = 10;
	localparam int unsigned DrainCycles  = 100;
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned Elements     = 1 << fpmm_pkg::IndexWidth;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_stall;
	logic [fpmm_pkg::IndexWidth-1:0]       element_index;
	logic signed [fpmm_pkg::DataWidth-1:0] left_value;
	logic signed [fpmm_pkg::DataWidth-1:0] right_value;
	logic                                  start_product;
	logic                                  out_valid;
	logic                                  out_stall;
	logic signed [fpmm_pkg::DataWidth-1:0] product_value;
	logic [fpmm_pkg::DimWidth-1:0]         product_row;
	logic [fpmm_pkg::DimWidth-1:0]         product_col;
	logic                                  final_result;

	int unsigned error_count;
	int unsigned elements_awaited;
	int unsigned loads_seen;
	int unsigned products_started;
	int unsigned elements_checked;
	int unsigned loads_sent;
	int unsigned cycle_count;
	logic        no_idle;

	fixed_point_matrix4_multiply #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.element_index(element_index),
		.left_value(left_value),
		.right_value(right_value),
		.start_product(start_product),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.product_value(product_value),
		.product_row(product_row),
		.product_col(product_col),
		.final_result(final_result)
	);

	fixed_point_matrix4_multiply_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.element_index(element_index),
		.left_value(left_value),
		.right_value(right_value),
		.start_product(start_product),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.product_value(product_value),
		.product_row(product_row),
		.product_col(product_col),
		.final_result(final_result),
		.error_count(error_count),
		.elements_awaited(elements_awaited),
		.loads_seen(loads_seen),
		.products_started(products_started),
		.elements_checked(elements_checked)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timed out after %0d cycles with %0d elements awaited",
				cycle_count, elements_awaited);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Element values weighted toward the extremes and small magnitudes.
	function automatic logic signed [fpmm_pkg::DataWidth-1:0] pick_value();
		logic signed [fpmm_pkg::DataWidth-1:0] v;
		int                                    raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: v = 16'sh8000;
			1: v = 16'sh7fff;
			2, 3: begin
				raw = $urandom_range(0, 64);
				raw = raw - 32;
				v   = raw[fpmm_pkg::DataWidth-1:0];
			end
			default: v = raw[fpmm_pkg::DataWidth-1:0];
		endcase
		return v;
	endfunction

	// Sends one load transfer after a random idle time; valid stays high
	// afterward so back-to-back transfers need no extra edge.
	task automatic send_load(input logic [fpmm_pkg::IndexWidth-1:0] idx,
			input logic signed [fpmm_pkg::DataWidth-1:0] lval,
			input logic signed [fpmm_pkg::DataWidth-1:0] rval, input logic start);
		int unsigned pause;
		pause = no_idle ? 0 : $urandom_range(0, MaxIdle);
		repeat (pause) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		element_index <= idx;
		left_value    <= lval;
		right_value   <= rval;
		start_product <= start;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		loads_sent++;
	endtask

	// Holds the load channel idle until every awaited element has arrived.
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (elements_awaited != 0) @(posedge clk);
	endtask

	// Result side: random stall before each transfer, none while no_idle is set.
	initial begin : result_sink
		int unsigned pause;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			pause = no_idle ? 0 : $urandom_range(0, MaxIdle);
			repeat (pause) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		logic [fpmm_pkg::IndexWidth-1:0] order [Elements];
		logic [fpmm_pkg::IndexWidth-1:0] tmp;
		int unsigned                     i;
		int unsigned                     j;
		int unsigned                     n;
		int unsigned                     pick;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element_index = '0;
		left_value    = '0;
		right_value   = '0;
		start_product = 1'b0;
		no_idle       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Product straight from the reset zeros.
		send_load(0, 0, 0, 1'b1);
		// Row 0 and column 0 at full scale so the sums wrap, most negative
		// operands squared, and small negatives that round toward minus infinity.
		send_load(0, 32767, 32767, 1'b0);
		send_load(1, 32767, -32768, 1'b0);
		send_load(2, 32767, -1, 1'b0);
		send_load(3, 32767, 1, 1'b0);
		send_load(4, -32768, 32767, 1'b0);
		send_load(5, -32768, -32768, 1'b0);
		send_load(8, -32768, 32767, 1'b0);
		send_load(12, -1, 32767, 1'b0);
		send_load(15, -32768, -32768, 1'b1);
		// Partial reload on top of the previous matrices.
		send_load(6, 16'sh1234, -16'sh0567, 1'b0);
		send_load(9, -16'sh7fff, 16'sh0100, 1'b0);
		send_load(10, -32768, 32767, 1'b1);
		hold_until_drained();

		// Random part: mostly complete loads, some partial loads and loose writes.
		while (loads_sent < ItemTarget) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					for (i = 0; i < Elements; i++) order[i] = i[fpmm_pkg::IndexWidth-1:0];
					if ($urandom_range(0, 1)) begin
						for (i = Elements - 1; i > 0; i--) begin
							j        = $urandom_range(0, i);
							tmp      = order[i];
							order[i] = order[j];
							order[j] = tmp;
						end
					end
					for (i = 0; i < Elements; i++)
						send_load(order[i], pick_value(), pick_value(), i == Elements - 1);
				end
				7, 8: begin
					n = $urandom_range(1, 6);
					for (i = 0; i < n; i++) begin
						pick = $urandom_range(0, Elements - 1);
						send_load(pick[fpmm_pkg::IndexWidth-1:0], pick_value(), pick_value(),
							i == n - 1);
					end
				end
				default: begin
					n = $urandom_range(1, 5);
					for (i = 0; i < n; i++) begin
						pick = $urandom_range(0, Elements - 1);
						send_load(pick[fpmm_pkg::IndexWidth-1:0], pick_value(), pick_value(),
							1'b0);
					end
				end
			endcase
			if ($urandom_range(0, 7) == 0) hold_until_drained();
		end

		hold_until_drained();
		repeat (DrainCycles) @(posedge clk);

		$display("Covered %0d load transfers and %0d products; %0d result transfers checked.",
			loads_seen, products_started, elements_checked);
		$display("Mismatches: %0d, elements still awaited: %0d.", error_count, elements_awaited);
		if (error_count == 0 && elements_awaited == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
